### design/dlr_pkg.sv
// dlr_pkg: shared types and constants of the line rasteriser
// used by dda_line_raster and its checker; no dependencies
`timescale 1ns / 1ps

package dlr_pkg;

  localparam int unsigned DLR_FRAME_WIDTH   = 256;
  localparam int unsigned DLR_FRAME_HEIGHT  = 256;
  localparam int unsigned DLR_SLOPE_FRAC    = 16;

  localparam int unsigned DLR_COORD_W  = 12;
  localparam int unsigned DLR_CHAN_W   = 8;
  localparam int unsigned DLR_COLOUR_W = 3 * DLR_CHAN_W;

  // command codes carried on op
  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_READ = 1'b1
  } dlr_op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PLOT_A,
    S_PLOT_B,
    S_DIV,
    S_WALK,
    S_RD_ADDR,
    S_RD_DATA
  } dlr_state_e;

endpackage

### design/dda_line_raster.sv
// dda_line_raster: line rasteriser over a colour frame store held in dlr_ram
// depends on dlr_pkg and dlr_ram
`timescale 1ns / 1ps

// usage
// - input channel (in_valid_i / in_stall_o) carries one request: op selects a
//   line draw (endpoints and colour) or a single pixel read (read coordinates)
// - output channel (out_valid_o / out_stall_i) returns the colour of a read
//   pixel; a draw returns nothing; a read outside the frame returns zero
// - one request at a time: the block stalls its input from acceptance until
//   the request is finished
// - draw: the endpoints first (S_PLOT_A, S_PLOT_B), then the bit-serial slope
//   divider over 12+SLOPE_FRACTION_BITS quotient bits (28 at the default),
//   then the walk: one pixel per column strictly between start and end, in
//   turn, set by the single memory write port, plus a closing step; a line
//   with end column not after start column finishes after the endpoints
// - read: the memory read is registered, then loaded into the output register;
//   the next request is not taken until that load
// - reset: a clearing pass writes zero to every pixel, one a cycle, all
//   FRAME_WIDTH*FRAME_HEIGHT of them (65536 at the default), with the input
//   stalled
// - a stalled result is held in the output register; a further read waits
//   in its final step until the register is free

module dda_line_raster
  import dlr_pkg::*;
#(
  parameter int unsigned FRAME_WIDTH         = DLR_FRAME_WIDTH,
  parameter int unsigned FRAME_HEIGHT        = DLR_FRAME_HEIGHT,
  parameter int unsigned SLOPE_FRACTION_BITS = DLR_SLOPE_FRAC
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   op_i,
  input  logic [DLR_COORD_W-1:0] start_column_i,
  input  logic [DLR_COORD_W-1:0] start_row_i,
  input  logic [DLR_COORD_W-1:0] end_column_i,
  input  logic [DLR_COORD_W-1:0] end_row_i,
  input  logic [DLR_CHAN_W-1:0]  red_in_i,
  input  logic [DLR_CHAN_W-1:0]  green_in_i,
  input  logic [DLR_CHAN_W-1:0]  blue_in_i,
  input  logic [DLR_COORD_W-1:0] read_column_i,
  input  logic [DLR_COORD_W-1:0] read_row_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DLR_CHAN_W-1:0]  red_out_o,
  output logic [DLR_CHAN_W-1:0]  green_out_o,
  output logic [DLR_CHAN_W-1:0]  blue_out_o
);

  localparam int unsigned ColW    = $clog2(FRAME_WIDTH);
  localparam int unsigned RowW    = $clog2(FRAME_HEIGHT);
  localparam int unsigned Depth   = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned NumW    = DLR_COORD_W + SLOPE_FRACTION_BITS;
  localparam int unsigned SlopeW  = NumW + 1;
  localparam int unsigned AccW    = NumW + 2;
  localparam int unsigned RowExtW = AccW - SLOPE_FRACTION_BITS;
  localparam int unsigned DivCntW = $clog2(NumW);

  // control state
  dlr_state_e         state_q, state_d;
  logic [AddrW-1:0]   clr_addr_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               pw_valid_q;
  logic               out_valid_q;

  // line and read context
  logic [DLR_COORD_W-1:0]  x1_q, y1_q, x2_q, y2_q;
  logic [DLR_COLOUR_W-1:0] colour_q;
  logic [DLR_COORD_W-1:0]  cur_col_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [SlopeW-1:0] slope_q;
  logic [NumW-1:0]         div_num_q;
  logic [DLR_COORD_W:0]    div_rem_q;
  logic [DLR_COORD_W-1:0]  dx_q;
  logic                    div_neg_q;
  logic [ColW-1:0]         pw_col_q;
  logic [RowW-1:0]         pw_row_q;
  logic [DLR_COORD_W-1:0]  rd_col_q, rd_row_q;
  logic                    rd_in_q;
  logic [DLR_CHAN_W-1:0]   out_r_q, out_g_q, out_b_q;

  // control outputs of the state machine
  logic in_stall;
  logic accept;
  logic plot_a, plot_b, walk;
  logic ram_re, clr_we;
  logic out_load;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall;

  // datapath helpers
  logic [DLR_COORD_W:0]     rem_sh, rem_nx;
  logic                     div_ge;
  logic [NumW-1:0]          num_nx;
  logic [DLR_COORD_W-1:0]   col_next;
  logic signed [AccW-1:0]   acc_next;
  logic                     walk_done;
  logic                     plot_req;
  logic [DLR_COORD_W-1:0]   plot_col;
  logic signed [RowExtW-1:0] plot_row;
  logic                     plot_in;
  logic [DLR_COORD_W-1:0]   dy_mag;
  logic [RowW-1:0]          mul_row;
  logic [ColW-1:0]          mul_col;
  logic [AddrW-1:0]         pix_addr, ram_addr;
  logic [DLR_COLOUR_W-1:0]  ram_wdata, ram_rdata;
  logic                     ram_we;
  logic                     rd_in_frame;

  // restoring divider step, one quotient bit a cycle
  assign rem_sh = {div_rem_q[DLR_COORD_W-1:0], div_num_q[NumW-1]};
  assign div_ge = rem_sh >= {1'b0, dx_q};
  assign rem_nx = div_ge ? (rem_sh - {1'b0, dx_q}) : rem_sh;
  assign num_nx = {div_num_q[NumW-2:0], div_ge};

  // column walk
  assign col_next  = cur_col_q + DLR_COORD_W'(1);
  assign acc_next  = acc_q + AccW'(slope_q);
  assign walk_done = col_next == x2_q;

  assign dy_mag = (end_row_i < start_row_i) ? (start_row_i - end_row_i)
                                            : (end_row_i - start_row_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_addr_q == AddrW'(Depth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_i == OP_READ) ? S_RD_ADDR : S_PLOT_A;
        end
      end
      S_PLOT_A:  state_d = S_PLOT_B;
      S_PLOT_B:  state_d = (x2_q > x1_q) ? S_DIV : S_IDLE;
      S_DIV: begin
        if (div_cnt_q == DivCntW'(NumW - 1)) state_d = S_WALK;
      end
      S_WALK: begin
        if (walk_done) state_d = S_IDLE;
      end
      S_RD_ADDR: state_d = S_RD_DATA;
      S_RD_DATA: begin
        if (out_free) state_d = S_IDLE;
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    plot_a   = 1'b0;
    plot_b   = 1'b0;
    walk     = 1'b0;
    ram_re   = 1'b0;
    clr_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_CLEAR:   clr_we   = 1'b1;
      S_IDLE:    in_stall = 1'b0;
      S_PLOT_A:  plot_a   = 1'b1;
      S_PLOT_B:  plot_b   = 1'b1;
      S_DIV:     ;
      S_WALK:    walk     = !walk_done;
      S_RD_ADDR: ram_re   = 1'b1;
      S_RD_DATA: out_load = out_free;
      default:   ;
    endcase
  end

  assign in_stall_o = in_stall;

  // pixel to plot this cycle, registered before the address multiply
  always_comb begin
    plot_req = plot_a || plot_b || walk;
    plot_col = x1_q;
    plot_row = RowExtW'({2'b00, y1_q});
    if (plot_b) begin
      plot_col = x2_q;
      plot_row = RowExtW'({2'b00, y2_q});
    end else if (walk) begin
      plot_col = col_next;
      plot_row = acc_next[AccW-1:SLOPE_FRACTION_BITS];  // floor of the row
    end
  end

  assign plot_in = ((DLR_COORD_W + 1)'(plot_col) < (DLR_COORD_W + 1)'(FRAME_WIDTH))
                && !plot_row[RowExtW-1]
                && ($unsigned(plot_row[DLR_COORD_W:0])
                    < (DLR_COORD_W + 1)'(FRAME_HEIGHT));

  assign rd_in_frame = ((DLR_COORD_W + 1)'(read_column_i)
                        < (DLR_COORD_W + 1)'(FRAME_WIDTH))
                    && ((DLR_COORD_W + 1)'(read_row_i)
                        < (DLR_COORD_W + 1)'(FRAME_HEIGHT));

  // one address multiplier, shared by pixel writes and the read
  assign mul_row  = (state_q == S_RD_ADDR) ? rd_row_q[RowW-1:0] : pw_row_q;
  assign mul_col  = (state_q == S_RD_ADDR) ? rd_col_q[ColW-1:0] : pw_col_q;
  assign pix_addr = AddrW'(mul_row) * AddrW'(FRAME_WIDTH) + AddrW'(mul_col);

  assign ram_we    = clr_we || pw_valid_q;
  assign ram_addr  = clr_we ? clr_addr_q : pix_addr;
  assign ram_wdata = clr_we ? '0 : colour_q;

  dlr_ram #(
    .WIDTH (DLR_COLOUR_W),
    .DEPTH (Depth)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      div_cnt_q   <= '0;
      pw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pw_valid_q <= plot_req && plot_in;
      if (clr_we) clr_addr_q <= clr_addr_q + AddrW'(1);
      if (state_q == S_DIV) begin
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end else begin
        div_cnt_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (op_i == OP_DRAW) begin
        x1_q      <= start_column_i;
        y1_q      <= start_row_i;
        x2_q      <= end_column_i;
        y2_q      <= end_row_i;
        colour_q  <= {red_in_i, green_in_i, blue_in_i};
        cur_col_q <= start_column_i;
        acc_q     <= AccW'({start_row_i, SLOPE_FRACTION_BITS'(0)});
        slope_q   <= '0;
        dx_q      <= end_column_i - start_column_i;
        div_neg_q <= end_row_i < start_row_i;
        div_num_q <= {dy_mag, SLOPE_FRACTION_BITS'(0)};
        div_rem_q <= '0;
      end else begin
        rd_col_q <= read_column_i;
        rd_row_q <= read_row_i;
        rd_in_q  <= rd_in_frame;
      end
    end
    if (state_q == S_DIV) begin
      div_num_q <= num_nx;
      div_rem_q <= rem_nx;
      if (div_cnt_q == DivCntW'(NumW - 1)) begin
        slope_q <= div_neg_q ? -$signed({1'b0, num_nx}) : $signed({1'b0, num_nx});
      end
    end
    if (walk) begin
      cur_col_q <= col_next;
      acc_q     <= acc_next;
    end
    if (plot_req) begin
      pw_col_q <= plot_col[ColW-1:0];
      pw_row_q <= plot_row[RowW-1:0];
    end
    if (out_load) begin
      out_r_q <= rd_in_q ? ram_rdata[2*DLR_CHAN_W +: DLR_CHAN_W] : '0;
      out_g_q <= rd_in_q ? ram_rdata[DLR_CHAN_W +: DLR_CHAN_W]   : '0;
      out_b_q <= rd_in_q ? ram_rdata[0 +: DLR_CHAN_W]            : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_r_q;
  assign green_out_o = out_g_q;
  assign blue_out_o  = out_b_q;

endmodule

### design/dlr_ram.sv
// dlr_ram: generic single-port synchronous ram, registered read data
// no dependencies
`timescale 1ns / 1ps

module dlr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/dlr_checker.sv
// dlr_checker: port-level assertions for dda_line_raster, bound to the top level
// depends on dlr_pkg
`timescale 1ns / 1ps

module dlr_checker
  import dlr_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   op_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [DLR_CHAN_W-1:0]  red_out_o,
  input logic [DLR_CHAN_W-1:0]  green_out_o,
  input logic [DLR_CHAN_W-1:0]  blue_out_o
);

  // a stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(red_out_o) && $stable(green_out_o)
                                   && $stable(blue_out_o))
    else $error("stalled result changed");

  // frame clearing holds off requests right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("request taken during frame clearing");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  // a new result traces back to an accepted read request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && (op_i == OP_READ), 3))
    else $error("result without a read request");

endmodule

bind dda_line_raster dlr_checker u_dlr_checker (.*);

### verif/dlr_raster_checker.sv
// dlr_raster_checker: watches both channels of dda_line_raster, predicts read colours
// from its own copy of the frame store and compares them with the returned results
// depends on dlr_pkg
`timescale 1ns / 1ps

module dlr_raster_checker
  import dlr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic                   op_i,
  input  logic [DLR_COORD_W-1:0] start_column_i,
  input  logic [DLR_COORD_W-1:0] start_row_i,
  input  logic [DLR_COORD_W-1:0] end_column_i,
  input  logic [DLR_COORD_W-1:0] end_row_i,
  input  logic [DLR_CHAN_W-1:0]  red_in_i,
  input  logic [DLR_CHAN_W-1:0]  green_in_i,
  input  logic [DLR_CHAN_W-1:0]  blue_in_i,
  input  logic [DLR_COORD_W-1:0] read_column_i,
  input  logic [DLR_COORD_W-1:0] read_row_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [DLR_CHAN_W-1:0]  red_out_i,
  input  logic [DLR_CHAN_W-1:0]  green_out_i,
  input  logic [DLR_CHAN_W-1:0]  blue_out_i,
  output int unsigned            fail_count_o,
  output int unsigned            due_count_o
);

  localparam longint FRAME_W_L = DLR_FRAME_WIDTH;
  localparam longint FRAME_H_L = DLR_FRAME_HEIGHT;
  localparam int unsigned PIXEL_COUNT = DLR_FRAME_WIDTH * DLR_FRAME_HEIGHT;

  typedef struct packed {
    logic [DLR_CHAN_W-1:0] red;
    logic [DLR_CHAN_W-1:0] green;
    logic [DLR_CHAN_W-1:0] blue;
  } pixel_t;

  pixel_t      frame_copy [PIXEL_COUNT];
  pixel_t      colours_due [$];
  pixel_t      oldest;
  int unsigned mismatches;

  // pixels off the frame are dropped
  function automatic void put_pixel(longint col, longint row, pixel_t colour);
    if (col < 0 || col >= FRAME_W_L || row < 0 || row >= FRAME_H_L) return;
    frame_copy[row * FRAME_W_L + col] = colour;
  endfunction

  function automatic pixel_t fetch_pixel(logic [DLR_COORD_W-1:0] col,
                                         logic [DLR_COORD_W-1:0] row);
    if (col >= DLR_FRAME_WIDTH || row >= DLR_FRAME_HEIGHT) return '0;
    return frame_copy[longint'(row) * FRAME_W_L + longint'(col)];
  endfunction

  // endpoints first, then one row per interior column from the fixed-point slope
  function automatic void rasterise_line(logic [DLR_COORD_W-1:0] x1,
                                         logic [DLR_COORD_W-1:0] y1,
                                         logic [DLR_COORD_W-1:0] x2,
                                         logic [DLR_COORD_W-1:0] y2,
                                         pixel_t colour);
    longint dy;
    longint slope;
    longint acc;
    longint x;
    put_pixel(longint'(x1), longint'(y1), colour);
    put_pixel(longint'(x2), longint'(y2), colour);
    if (x2 <= x1) return;
    dy = longint'(y2) - longint'(y1);
    // magnitude divided and truncated, sign applied afterwards
    slope = ((dy < 0 ? -dy : dy) <<< DLR_SLOPE_FRAC) / (longint'(x2) - longint'(x1));
    if (dy < 0) slope = -slope;
    acc = longint'(y1) <<< DLR_SLOPE_FRAC;
    for (x = longint'(x1) + 1; x < longint'(x2); x++) begin
      acc += slope;
      put_pixel(x, acc >>> DLR_SLOPE_FRAC, colour);
    end
  endfunction

  task automatic check_channel(string name, logic [DLR_CHAN_W-1:0] want,
                               logic [DLR_CHAN_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (frame_copy[k]) frame_copy[k] = '0;
      colours_due.delete();
      mismatches = 0;
      fail_count_o <= 0;
      due_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_DRAW) begin
          rasterise_line(start_column_i, start_row_i, end_column_i, end_row_i,
                         {red_in_i, green_in_i, blue_in_i});
        end else begin
          colours_due.push_back(fetch_pixel(read_column_i, read_row_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (colours_due.size() == 0) begin
          $display("%0t: result with no read outstanding, expected none actual %02h %02h %02h",
                   $time, red_out_i, green_out_i, blue_out_i);
          mismatches++;
        end else begin
          oldest = colours_due.pop_front();
          check_channel("red", oldest.red, red_out_i);
          check_channel("green", oldest.green, green_out_i);
          check_channel("blue", oldest.blue, blue_out_i);
        end
      end
      fail_count_o <= mismatches;
      due_count_o <= colours_due.size();
    end
  end

endmodule

### verif/dda_line_raster_tb.sv
// dda_line_raster_tb: drives draw and read requests into dda_line_raster with random
// idling on both channels and gives the verdict; depends on dlr_pkg, dda_line_raster
// and dlr_raster_checker
`timescale 1ns / 1ps

module dda_line_raster_tb
  import dlr_pkg::*;
();

  localparam int unsigned MAX_GAP       = 17;
  localparam int unsigned LONG_HOLD     = 600;
  localparam int unsigned BURST_READS   = 12;
  localparam int unsigned SEGMENTS      = 10;
  localparam int unsigned SEG_REQUESTS  = 63;
  localparam int unsigned HISTORY_DEPTH = 8;
  // the limit outlasts the reset clearing pass and the longest draw
  localparam int unsigned STALL_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 100;

  typedef struct packed {
    dlr_op_e                op;
    logic [DLR_COORD_W-1:0] start_column;
    logic [DLR_COORD_W-1:0] start_row;
    logic [DLR_COORD_W-1:0] end_column;
    logic [DLR_COORD_W-1:0] end_row;
    logic [DLR_CHAN_W-1:0]  red;
    logic [DLR_CHAN_W-1:0]  green;
    logic [DLR_CHAN_W-1:0]  blue;
    logic [DLR_COORD_W-1:0] read_column;
    logic [DLR_COORD_W-1:0] read_row;
  } request_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   op_i = OP_DRAW;
  logic [DLR_COORD_W-1:0] start_column_i = '0;
  logic [DLR_COORD_W-1:0] start_row_i = '0;
  logic [DLR_COORD_W-1:0] end_column_i = '0;
  logic [DLR_COORD_W-1:0] end_row_i = '0;
  logic [DLR_CHAN_W-1:0]  red_in_i = '0;
  logic [DLR_CHAN_W-1:0]  green_in_i = '0;
  logic [DLR_CHAN_W-1:0]  blue_in_i = '0;
  logic [DLR_COORD_W-1:0] read_column_i = '0;
  logic [DLR_COORD_W-1:0] read_row_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [DLR_CHAN_W-1:0]  red_out_o;
  logic [DLR_CHAN_W-1:0]  green_out_o;
  logic [DLR_CHAN_W-1:0]  blue_out_o;

  int unsigned fail_count;
  int unsigned pending_reads;
  int unsigned idle_cycles = 0;

  // idling modes, switched per segment of the random part
  bit tx_busy = 1'b0;
  bit rx_busy = 1'b0;
  // asks the receiver for one long hold-off so the block backs up
  bit long_hold_ask = 1'b0;

  // lines drawn lately, so that reads land on pixels that were written
  request_t recent_lines [$];

  always #1 clk_i = ~clk_i;

  dda_line_raster dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .start_column_i (start_column_i),
    .start_row_i    (start_row_i),
    .end_column_i   (end_column_i),
    .end_row_i      (end_row_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .read_column_i  (read_column_i),
    .read_row_i     (read_row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o)
  );

  dlr_raster_checker raster_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .op_i           (op_i),
    .start_column_i (start_column_i),
    .start_row_i    (start_row_i),
    .end_column_i   (end_column_i),
    .end_row_i      (end_row_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .read_column_i  (read_column_i),
    .read_row_i     (read_row_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_out_i      (red_out_o),
    .green_out_i    (green_out_o),
    .blue_out_i     (blue_out_o),
    .fail_count_o   (fail_count),
    .due_count_o    (pending_reads)
  );

  // colour channels lean on the extremes now and then
  function automatic logic [DLR_CHAN_W-1:0] colour_byte();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return DLR_CHAN_W'($urandom_range(0, 255));
  endfunction

  // draw request; the read fields carry noise the block must ignore
  function automatic request_t make_draw(int sc, int sr, int ec, int er,
                                         logic [DLR_CHAN_W-1:0] red,
                                         logic [DLR_CHAN_W-1:0] green,
                                         logic [DLR_CHAN_W-1:0] blue);
    request_t req;
    req.op           = OP_DRAW;
    req.start_column = DLR_COORD_W'(sc);
    req.start_row    = DLR_COORD_W'(sr);
    req.end_column   = DLR_COORD_W'(ec);
    req.end_row      = DLR_COORD_W'(er);
    req.red          = red;
    req.green        = green;
    req.blue         = blue;
    req.read_column  = DLR_COORD_W'($urandom_range(0, 4095));
    req.read_row     = DLR_COORD_W'($urandom_range(0, 4095));
    return req;
  endfunction

  // read request; the line fields carry noise the block must ignore
  function automatic request_t make_read(int col, int row);
    request_t req;
    req.op           = OP_READ;
    req.start_column = DLR_COORD_W'($urandom_range(0, 4095));
    req.start_row    = DLR_COORD_W'($urandom_range(0, 4095));
    req.end_column   = DLR_COORD_W'($urandom_range(0, 4095));
    req.end_row      = DLR_COORD_W'($urandom_range(0, 4095));
    req.red          = DLR_CHAN_W'($urandom_range(0, 255));
    req.green        = DLR_CHAN_W'($urandom_range(0, 255));
    req.blue         = DLR_CHAN_W'($urandom_range(0, 255));
    req.read_column  = DLR_COORD_W'(col);
    req.read_row     = DLR_COORD_W'(row);
    return req;
  endfunction

  // optional idle gap, then hold the request until the block takes it;
  // returns at the edge of acceptance so the next request can follow directly
  task automatic send_request(input request_t req);
    int unsigned gap;
    gap = tx_busy ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_i           <= req.op;
    start_column_i <= req.start_column;
    start_row_i    <= req.start_row;
    end_column_i   <= req.end_column;
    end_row_i      <= req.end_row;
    red_in_i       <= req.red;
    green_in_i     <= req.green;
    blue_in_i      <= req.blue;
    read_column_i  <= req.read_column;
    read_row_i     <= req.read_row;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // sender goes quiet until every read result is back
  task automatic wait_reads_returned();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_reads != 0);
  endtask

  // result side: a random hold-off before each result, or none in calm segments,
  // or one long hold-off when asked for
  initial begin : result_receiver
    int unsigned hold;
    forever begin
      if (long_hold_ask) begin
        hold = LONG_HOLD;
        long_hold_ask = 1'b0;
      end else begin
        hold = rx_busy ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // watchdog: too long without a request or result moving means a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    request_t    req;
    request_t    line;
    int unsigned seg;
    int unsigned n;
    int          kind;
    int          sc;
    int          sr;
    int          ec;
    int          er;
    int          col;
    int          row;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part; the first request waits out the clearing pass
    send_request(make_read(0, 0));                          // cleared store
    send_request(make_read(4095, 4095));                    // read off the frame
    send_request(make_draw(0, 0, 255, 255, 8'hff, 8'hff, 8'hff));  // full diagonal
    send_request(make_read(128, 128));
    send_request(make_read(255, 255));
    send_request(make_draw(10, 200, 250, 5, 8'h00, 8'hff, 8'h00)); // falling slope
    send_request(make_read(10, 200));
    send_request(make_read(250, 5));
    // end column before start column: endpoints only
    send_request(make_draw(200, 50, 100, 60, 8'h12, 8'h34, 8'h56));
    send_request(make_read(100, 60));
    send_request(make_read(150, 55));
    // equal columns: vertical line collapses to its endpoints
    send_request(make_draw(40, 0, 40, 255, 8'h80, 8'h00, 8'h80));
    // steep line leaving the bottom of the frame
    send_request(make_draw(0, 100, 255, 4095, 8'ha5, 8'h5a, 8'hc3));
    send_request(make_read(1, 115));
    send_request(make_read(5, 178));
    // walk entirely right of the frame, then a reversed line fully outside
    send_request(make_draw(300, 10, 4095, 4095, 8'h01, 8'h02, 8'h03));
    send_request(make_draw(4095, 0, 0, 4095, 8'hff, 8'h00, 8'hff));
    send_request(make_draw(0, 255, 255, 0, 8'h7f, 8'h80, 8'hfe));  // anti-diagonal
    send_request(make_read(0, 255));
    send_request(make_read(255, 0));
    send_request(make_read(4095, 0));
    send_request(make_read(0, 4095));
    send_request(make_read(256, 128));
    send_request(make_read(127, 128));

    // random part: segments alternate calm, busy sender, busy receiver and both
    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 3) begin
        // back-to-back reads against a long receiver hold-off fill the block
        tx_busy = 1'b0;
        long_hold_ask = 1'b1;
        repeat (BURST_READS)
          send_request(make_read($urandom_range(0, 255), $urandom_range(0, 255)));
      end
      tx_busy = seg[0];
      rx_busy = seg[1];
      for (n = 0; n < SEG_REQUESTS; n++) begin
        if (recent_lines.size() == 0 || $urandom_range(0, 99) < 45) begin
          kind = $urandom_range(0, 99);
          if (kind < 65) begin
            // ordinary line, mostly inside the frame
            sc = $urandom_range(0, 255);
            ec = sc + $urandom_range(0, 100);
            sr = $urandom_range(0, 300);
            er = $urandom_range(0, 300);
          end else if (kind < 80) begin
            // end column not after start column
            sc = $urandom_range(0, 300);
            ec = $urandom_range(0, sc);
            sr = $urandom_range(0, 300);
            er = $urandom_range(0, 300);
          end else if (kind < 95) begin
            // around the right and bottom edges
            sc = $urandom_range(180, 300);
            ec = sc + $urandom_range(0, 120);
            sr = $urandom_range(180, 320);
            er = $urandom_range(0, 400);
          end else begin
            // full coordinate range, occasionally a very long walk
            sc = $urandom_range(0, 4095);
            ec = $urandom_range(0, 4095);
            sr = $urandom_range(0, 4095);
            er = $urandom_range(0, 4095);
          end
          if (ec > 4095) ec = 4095;
          req = make_draw(sc, sr, ec, er, colour_byte(), colour_byte(), colour_byte());
          recent_lines.push_back(req);
          if (recent_lines.size() > HISTORY_DEPTH) void'(recent_lines.pop_front());
        end else begin
          line = recent_lines[$urandom_range(0, recent_lines.size() - 1)];
          sc = int'(line.start_column);
          sr = int'(line.start_row);
          ec = int'(line.end_column);
          er = int'(line.end_row);
          kind = $urandom_range(0, 99);
          if (kind < 40) begin
            // one of the endpoints
            col = kind[0] ? sc : ec;
            row = kind[0] ? sr : er;
          end else if (kind < 75 && ec > sc + 1) begin
            // near the walked row; an off-by-one lands on a neighbour, also fine
            col = $urandom_range(sc + 1, ec - 1);
            row = sr + (er - sr) * (col - sc) / (ec - sc);
          end else if (kind < 90) begin
            col = $urandom_range(0, 255);
            row = $urandom_range(0, 255);
          end else begin
            col = $urandom_range(0, 4095);
            row = $urandom_range(0, 4095);
          end
          req = make_read(col, row);
        end
        send_request(req);
      end
      if (seg % 3 == 2) wait_reads_returned();
    end

    wait_reads_returned();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
